/* rtl/hrlc_pkg.sv */
package hrlc_pkg;

	localparam int MAX_EXT_LEN = 4;
	localparam int EXT_LIMIT = (MAX_EXT_LEN < 7) ? MAX_EXT_LEN : 7;
	localparam int EXT_COUNT = 9;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [2:0] V_OK      = 3'd0;
	localparam logic [2:0] V_METHOD  = 3'd1;
	localparam logic [2:0] V_PROTO   = 3'd2;
	localparam logic [2:0] V_EXT     = 3'd3;
	localparam logic [2:0] V_MISSING = 3'd4;

	typedef enum logic [5:0] {
		PH_SKIP_METHOD = 6'b000001,
		PH_METHOD      = 6'b000010,
		PH_SKIP_PATH   = 6'b000100,
		PH_PATH        = 6'b001000,
		PH_SKIP_CR     = 6'b010000,
		PH_PROTO       = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic       media_kind;
		logic [3:0] media_subtype;
		logic       default_index;
	} res_t;

	// Extensions are packed first character in the low byte, zero filled.
	localparam logic [2:0] EXT_LEN [EXT_COUNT] = '{
		3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3};
	localparam logic [31:0] EXT_PACK [EXT_COUNT] = '{
		32'h6C6D7468, 32'h006D7468, 32'h00737363, 32'h0000736A, 32'h00747874,
		32'h00666967, 32'h0067706A, 32'h6765706A, 32'h00676E70};
	localparam logic EXT_KIND [EXT_COUNT] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
	localparam logic [3:0] EXT_SUB [EXT_COUNT] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};

	function automatic logic [7:0] get_char(input logic [1:0] pos);
		logic [7:0] c;
		unique case (pos)
			2'd0: c = 8'h47;
			2'd1: c = 8'h45;
			2'd2: c = 8'h54;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] proto_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h48;
			3'd1: c = 8'h54;
			3'd2: c = 8'h54;
			3'd3: c = 8'h50;
			3'd4: c = 8'h2F;
			3'd5: c = 8'h31;
			3'd6: c = 8'h2E;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// Protocol match flag after one more protocol byte.
	function automatic logic proto_next(input logic pm, input logic [3:0] pos,
		input logic [7:0] b);
		logic r;
		r = pm;
		if (pos < 4'd7) begin
			if (b != proto_char(pos[2:0]))
				r = 1'b0;
		end else if (pos == 4'd7) begin
			if (b != CH_ZERO && b != CH_ONE)
				r = 1'b0;
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

	function automatic res_t judge(input logic mm, input logic pm, input logic [7:0] lpb,
		input logic dot, input logic long_ext, input logic [2:0] el, input logic [31:0] eb);
		res_t r;
		r = '0;
		if (!mm) begin
			r.verdict = V_METHOD;
		end else if (!pm) begin
			r.verdict = V_PROTO;
		end else if (lpb == CH_SLASH) begin
			r.verdict = V_OK;
			r.default_index = 1'b1;
		end else if (!dot) begin
			r.verdict = V_MISSING;
		end else begin
			r.verdict = V_EXT;
			if (!long_ext) begin
				// Walk downward so the first table entry that matches wins.
				for (int i = EXT_COUNT - 1; i >= 0; i--) begin
					if (EXT_LEN[i] == el && EXT_PACK[i] == eb) begin
						r.verdict = V_OK;
						r.media_kind = EXT_KIND[i];
						r.media_subtype = EXT_SUB[i];
					end
				end
			end
		end
		return r;
	endfunction

endpackage

/* rtl/hrlc_if.sv */
interface hrlc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_request;

	modport source(output valid, output data_byte, output end_of_request, input ready);
	modport sink(input valid, input data_byte, input end_of_request, output ready);
endinterface

interface hrlc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic       media_kind;
	logic [3:0] media_subtype;
	logic       default_index;

	modport source(output valid, output verdict, output media_kind, output media_subtype,
		output default_index, input ready);
	modport sink(input valid, input verdict, input media_kind, input media_subtype,
		input default_index, output ready);
endinterface

/* rtl/http_request_line_classifier_unit.sv */
// HTTP request line classifier.
// Channel req carries the request one byte per transaction (data_byte) with
// end_of_request marking the last byte of the buffer. Channel rsp carries one
// verdict per request: verdict, media_kind, media_subtype and default_index.
// A verdict appears when a carriage return closes the protocol token, or at a
// zero byte or the end_of_request byte if none was given yet; bytes after a
// verdict are dropped until end_of_request, which also clears the parser.
// A byte is taken into an input register and classified by the parser from
// there; its verdict, if any, lands in the output register that drives rsp.
// Throughput is one byte per cycle while rsp does not stall, set by the single
// parser stage that updates its state once per byte.
// When rsp stalls, the input register holds its byte and req.ready drops
// once that register is full; the output register keeps its verdict stable.
// Reset (arst_n low) empties both registers and returns the parser to the
// start of a request.
module http_request_line_classifier_unit (
	input  logic         clk,
	input  logic         arst_n,
	hrlc_in_if.sink      req,
	hrlc_out_if.source   rsp
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                advance;
	logic                res_valid;
	hrlc_pkg::res_t      res;
	logic                out_valid_q;
	hrlc_pkg::res_t      out_q;

	assign advance = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			byte_s1 <= req.data_byte;
			last_s1 <= req.end_of_request;
		end
	end

	hrlc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (valid_s1 && advance),
		.data_byte (byte_s1),
		.last      (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1 && res_valid;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid)
			out_q <= res;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.verdict = out_q.verdict;
	assign rsp.media_kind = out_q.media_kind;
	assign rsp.media_subtype = out_q.media_subtype;
	assign rsp.default_index = out_q.default_index;

endmodule

/* rtl/hrlc_core.sv */
module hrlc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          data_byte,
	input  logic                last,
	output logic                res_valid,
	output hrlc_pkg::res_t      res
);

	hrlc_pkg::phase_t phase_q, n_phase;
	logic [3:0]  pos_q, n_pos;
	logic        mm_q, n_mm;
	logic        pm_q, n_pm;
	logic        dot_q, n_dot;
	logic [31:0] eb_q, n_eb;
	logic [2:0]  el_q, n_el;
	logic        long_q, n_long;
	logic [7:0]  lpb_q, n_lpb;
	logic        sent_q, n_sent;

	always_comb begin
		logic stop;
		logic mm_f;
		stop = 1'b0;
		mm_f = 1'b0;
		n_phase = phase_q;
		n_pos = pos_q;
		n_mm = mm_q;
		n_pm = pm_q;
		n_dot = dot_q;
		n_eb = eb_q;
		n_el = el_q;
		n_long = long_q;
		n_lpb = lpb_q;
		n_sent = sent_q;
		res_valid = 1'b0;
		res = '0;

		if (!sent_q && data_byte != hrlc_pkg::CH_NUL) begin
			if (n_phase == hrlc_pkg::PH_SKIP_METHOD) begin
				if (data_byte == hrlc_pkg::CH_SP) begin
					stop = 1'b1;
				end else begin
					n_phase = hrlc_pkg::PH_METHOD;
					n_pos = 4'd0;
					n_mm = 1'b1;
				end
			end
			if (!stop && n_phase == hrlc_pkg::PH_METHOD) begin
				stop = 1'b1;
				if (data_byte == hrlc_pkg::CH_SP) begin
					n_mm = n_mm && n_pos == 4'd3;
					n_phase = hrlc_pkg::PH_SKIP_PATH;
				end else begin
					if (n_pos >= 4'd3 || data_byte != hrlc_pkg::get_char(n_pos[1:0]))
						n_mm = 1'b0;
					if (n_pos != 4'd15)
						n_pos = n_pos + 4'd1;
				end
			end
			if (!stop && n_phase == hrlc_pkg::PH_SKIP_PATH) begin
				if (data_byte == hrlc_pkg::CH_SP)
					stop = 1'b1;
				else
					n_phase = hrlc_pkg::PH_PATH;
			end
			if (!stop && n_phase == hrlc_pkg::PH_PATH) begin
				stop = 1'b1;
				if (data_byte == hrlc_pkg::CH_SP) begin
					n_phase = hrlc_pkg::PH_SKIP_CR;
				end else begin
					n_lpb = data_byte;
					if (data_byte == hrlc_pkg::CH_DOT) begin
						n_dot = 1'b1;
						n_eb = '0;
						n_el = '0;
						n_long = 1'b0;
					end else if (dot_q && !long_q) begin
						if (el_q >= 3'(hrlc_pkg::EXT_LIMIT)) begin
							n_long = 1'b1;
						end else begin
							// Only the first four extension bytes are kept.
							if (!el_q[2])
								n_eb[{el_q[1:0], 3'b000} +: 8] = data_byte;
							n_el = el_q + 3'd1;
						end
					end
				end
			end
			if (!stop && n_phase == hrlc_pkg::PH_SKIP_CR) begin
				stop = 1'b1;
				if (data_byte != hrlc_pkg::CH_CR) begin
					n_phase = hrlc_pkg::PH_PROTO;
					n_pm = hrlc_pkg::proto_next(1'b1, 4'd0, data_byte);
					n_pos = 4'd1;
				end
			end
			if (!stop && n_phase == hrlc_pkg::PH_PROTO) begin
				if (data_byte == hrlc_pkg::CH_CR) begin
					n_pm = n_pm && n_pos == 4'd8;
					res = hrlc_pkg::judge(n_mm, n_pm, n_lpb, n_dot, n_long, n_el, n_eb);
					res_valid = 1'b1;
				end else begin
					n_pm = hrlc_pkg::proto_next(n_pm, n_pos, data_byte);
					if (n_pos != 4'd15)
						n_pos = n_pos + 4'd1;
				end
			end
		end

		// The request text ended before a carriage return closed the protocol.
		if (!sent_q && !res_valid && (data_byte == hrlc_pkg::CH_NUL || last)) begin
			res_valid = 1'b1;
			mm_f = (n_phase == hrlc_pkg::PH_METHOD) ? (n_mm && n_pos == 4'd3) : n_mm;
			if (n_phase == hrlc_pkg::PH_SKIP_METHOD)
				res.verdict = hrlc_pkg::V_MISSING;
			else if (!mm_f)
				res.verdict = hrlc_pkg::V_METHOD;
			else if (n_phase == hrlc_pkg::PH_PROTO)
				res = hrlc_pkg::judge(mm_f, n_pm && n_pos == 4'd8, n_lpb, n_dot, n_long,
					n_el, n_eb);
			else
				res.verdict = hrlc_pkg::V_MISSING;
		end

		if (res_valid)
			n_sent = 1'b1;

		if (last) begin
			n_phase = hrlc_pkg::PH_SKIP_METHOD;
			n_pos = '0;
			n_mm = 1'b1;
			n_pm = 1'b1;
			n_dot = 1'b0;
			n_eb = '0;
			n_el = '0;
			n_long = 1'b0;
			n_lpb = '0;
			n_sent = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrlc_pkg::PH_SKIP_METHOD;
			pos_q <= '0;
			mm_q <= 1'b1;
			pm_q <= 1'b1;
			dot_q <= 1'b0;
			eb_q <= '0;
			el_q <= '0;
			long_q <= 1'b0;
			lpb_q <= '0;
			sent_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= n_phase;
			pos_q <= n_pos;
			mm_q <= n_mm;
			pm_q <= n_pm;
			dot_q <= n_dot;
			eb_q <= n_eb;
			el_q <= n_el;
			long_q <= n_long;
			lpb_q <= n_lpb;
			sent_q <= n_sent;
		end
	end

endmodule

/* rtl/hrlc_checker.sv */
module hrlc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] verdict,
	input logic       media_kind,
	input logic [3:0] media_subtype,
	input logic       default_index
);

	// A stalled verdict must not change under the receiver.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(media_kind)
			&& $stable(media_subtype) && $stable(default_index))
		else $error("verdict changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= hrlc_pkg::V_MISSING && media_subtype <= 4'd8)
		else $error("verdict or subtype out of range");

	// Only an accepted request carries media information.
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict != hrlc_pkg::V_OK |->
			!media_kind && media_subtype == 4'd0 && !default_index)
		else $error("rejected request carries media fields");

	// An implied index page is always text html.
	a_index_html: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && default_index |-> !media_kind && media_subtype == 4'd0)
		else $error("default index is not html");

	// Images and text split at the gif subtype.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == hrlc_pkg::V_OK |-> media_kind == (media_subtype >= 4'd5))
		else $error("media kind disagrees with subtype");

endmodule

bind http_request_line_classifier_unit hrlc_checker u_hrlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.verdict       (rsp.verdict),
	.media_kind    (rsp.media_kind),
	.media_subtype (rsp.media_subtype),
	.default_index (rsp.default_index)
);
